@@ hw/rtl/rmq_pkg.sv @@
package rmq_pkg;

   // Fixed point format: signed Q2.FRAC_BITS
   localparam int FRAC_BITS = 16;
   localparam int VAL_W     = FRAC_BITS + 2;
   localparam int EXT_W     = VAL_W + 3;           // trace and combination math
   localparam int D_W       = VAL_W + 1;           // off-diagonal sum or difference
   localparam int T_W       = VAL_W + 1;           // clamped combination, unsigned
   localparam int N_W       = T_W + FRAC_BITS;     // square root radicand
   localparam int SQ_W      = N_W + (N_W % 2);
   localparam int ROOT_W    = SQ_W / 2;
   localparam int DV_W      = ROOT_W + 1;          // divisor 2*root
   localparam int Q_W       = VAL_W + 1;           // quotient magnitude bits

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic signed [D_W-1:0]   diff_type;
   typedef logic [1:0]              branch_type;

   // Branch codes
   localparam branch_type BR_TRACE = 2'd0;
   localparam branch_type BR_X     = 2'd1;
   localparam branch_type BR_Y     = 2'd2;
   localparam branch_type BR_Z     = 2'd3;

   localparam val_type VAL_MAX = val_type'((1 << (VAL_W - 1)) - 1);
   localparam val_type VAL_MIN = val_type'(-(1 << (VAL_W - 1)));

   // Data that rides along the square root pipeline
   typedef struct packed {
      branch_type branch;
      diff_type   dx;
      diff_type   dy;
      diff_type   dz;
      diff_type   dw;
   } side_type;

endpackage

@@ hw/rtl/rotation_matrix_to_quaternion_unit.sv @@
// Channel  Ports   Direction  Contents
// req      req_*   in         matrix elements r11..r33, Q2.16
// rsp      rsp_*   out        quaternion qx qy qz qw, Q2.16, and branch_taken
//
// One item per cycle sustained while rsp is not stalled. At Q2.16 the
// pipeline is one select stage, one load plus one stage per root bit in
// the square root, one prep plus one stage per quotient bit in the
// divider, and the output register. Reset clears only the valid bits.
// An rsp stall freezes all stages and drops req_ready in the same cycle.
module rotation_matrix_to_quaternion_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rmq_pkg::val_type     req_r11,
   input  rmq_pkg::val_type     req_r12,
   input  rmq_pkg::val_type     req_r13,
   input  rmq_pkg::val_type     req_r21,
   input  rmq_pkg::val_type     req_r22,
   input  rmq_pkg::val_type     req_r23,
   input  rmq_pkg::val_type     req_r31,
   input  rmq_pkg::val_type     req_r32,
   input  rmq_pkg::val_type     req_r33,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rmq_pkg::val_type     rsp_qx,
   output rmq_pkg::val_type     rsp_qy,
   output rmq_pkg::val_type     rsp_qz,
   output rmq_pkg::val_type     rsp_qw,
   output rmq_pkg::branch_type  rsp_branch_taken
);
   import rmq_pkg::*;

   localparam logic signed [EXT_W-1:0] FIX_ONE = EXT_W'(1 << FRAC_BITS);

   logic                      en;
   logic signed [EXT_W-1:0]   e11, e22, e33, trace, comb;
   side_type                  side_in;
   logic [T_W-1:0]            t_in;
   logic                      a_valid_ff;
   logic [T_W-1:0]            t_ff;
   side_type                  side_ff;
   logic                      sq_valid;
   logic [ROOT_W-1:0]         sq_root;
   side_type                  sq_side;

   // Global advance: move whenever the output register can drain
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Branch select, combination and off-diagonal terms
   assign e11   = EXT_W'(req_r11);
   assign e22   = EXT_W'(req_r22);
   assign e33   = EXT_W'(req_r33);
   assign trace = e11 + e22 + e33;

   always_comb begin
      side_in.dx = '0;
      side_in.dy = '0;
      side_in.dz = '0;
      side_in.dw = '0;
      if (trace > 0) begin
         side_in.branch = BR_TRACE;
         comb = trace + FIX_ONE;
         side_in.dx = D_W'(req_r32) - D_W'(req_r23);
         side_in.dy = D_W'(req_r13) - D_W'(req_r31);
         side_in.dz = D_W'(req_r21) - D_W'(req_r12);
      end else if (req_r11 > req_r22 && req_r11 > req_r33) begin
         side_in.branch = BR_X;
         comb = FIX_ONE + e11 - e22 - e33;
         side_in.dw = D_W'(req_r32) - D_W'(req_r23);
         side_in.dy = D_W'(req_r12) + D_W'(req_r21);
         side_in.dz = D_W'(req_r13) + D_W'(req_r31);
      end else if (req_r22 > req_r33) begin
         side_in.branch = BR_Y;
         comb = FIX_ONE + e22 - e11 - e33;
         side_in.dw = D_W'(req_r13) - D_W'(req_r31);
         side_in.dx = D_W'(req_r12) + D_W'(req_r21);
         side_in.dz = D_W'(req_r23) + D_W'(req_r32);
      end else begin
         side_in.branch = BR_Z;
         comb = FIX_ONE + e33 - e11 - e22;
         side_in.dw = D_W'(req_r21) - D_W'(req_r12);
         side_in.dx = D_W'(req_r13) + D_W'(req_r31);
         side_in.dy = D_W'(req_r23) + D_W'(req_r32);
      end
      // clamp the combination at zero
      t_in = (comb < 0) ? '0 : comb[T_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
      end
      if (en) begin
         t_ff    <= t_in;
         side_ff <= side_in;
      end
   end

   rmq_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_valid_ff),
      .in_t      (t_ff),
      .in_side   (side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   rmq_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (sq_valid),
      .in_root    (sq_root),
      .in_side    (sq_side),
      .out_valid  (rsp_valid),
      .out_qx     (rsp_qx),
      .out_qy     (rsp_qy),
      .out_qz     (rsp_qz),
      .out_qw     (rsp_qw),
      .out_branch (rsp_branch_taken)
   );

   // The component taken from the root is never negative
   a_big_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_branch_taken != BR_TRACE || !rsp_qw[VAL_W-1]) &&
                    (rsp_branch_taken != BR_X || !rsp_qx[VAL_W-1]) &&
                    (rsp_branch_taken != BR_Y || !rsp_qy[VAL_W-1]) &&
                    (rsp_branch_taken != BR_Z || !rsp_qz[VAL_W-1]))
      else $error("root component negative");

   // Pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A held result freezes intake
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken during output stall");

endmodule

@@ hw/rtl/rmq_isqrt.sv @@
module rmq_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [rmq_pkg::T_W-1:0]       in_t,
   input  rmq_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [rmq_pkg::ROOT_W-1:0]    out_root,
   output rmq_pkg::side_type             out_side
);
   import rmq_pkg::*;

   logic                valid_ff [0:ROOT_W];
   logic [SQ_W-1:0]     n_ff     [0:ROOT_W];
   logic [ROOT_W+1:0]   rem_ff   [0:ROOT_W];
   logic [ROOT_W-1:0]   root_ff  [0:ROOT_W];
   side_type            side_ff  [0:ROOT_W];

   // Load stage: radicand is t scaled by 2^FRAC_BITS
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         n_ff[0]    <= SQ_W'(in_t) << FRAC_BITS;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   // One root bit per stage
   for (genvar g = 0; g < ROOT_W; g++) begin : g_bit
      logic [ROOT_W+1:0] rem_sh;
      logic [ROOT_W+1:0] trial;
      logic              ge;

      assign rem_sh = {rem_ff[g][ROOT_W-1:0], n_ff[g][SQ_W-1 -: 2]};
      assign trial  = {root_ff[g], 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g+1] <= 1'b0;
         end else if (en) begin
            valid_ff[g+1] <= valid_ff[g];
         end
         if (en) begin
            n_ff[g+1]    <= n_ff[g] << 2;
            rem_ff[g+1]  <= ge ? (rem_sh - trial) : rem_sh;
            root_ff[g+1] <= {root_ff[g][ROOT_W-2:0], ge};
            side_ff[g+1] <= side_ff[g];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

endmodule

@@ hw/rtl/rmq_div.sv @@
module rmq_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [rmq_pkg::ROOT_W-1:0]  in_root,
   input  rmq_pkg::side_type           in_side,
   output logic                        out_valid,
   output rmq_pkg::val_type            out_qx,
   output rmq_pkg::val_type            out_qy,
   output rmq_pkg::val_type            out_qz,
   output rmq_pkg::val_type            out_qw,
   output rmq_pkg::branch_type         out_branch
);
   import rmq_pkg::*;

   typedef struct packed {
      logic             neg;
      logic             ovf;
      logic [DV_W-1:0]  rem;
      logic [Q_W-1:0]   num;
      logic [Q_W-1:0]   quo;
   } lane_type;

   typedef struct packed {
      branch_type        branch;
      logic [DV_W-1:0]   dv;
      val_type           bigv;
      lane_type [3:0]    lane;
   } dstage_type;

   logic        valid_ff [0:Q_W];
   dstage_type  st_ff    [0:Q_W];
   dstage_type  st_in;
   diff_type    dd [4];
   logic [ROOT_W-1:0] root1;

   logic        out_valid_ff;
   val_type     q_ff [4];
   branch_type  branch_ff;

   // Prep: divisor, magnitudes, overflow precheck
   assign dd[0] = in_side.dx;
   assign dd[1] = in_side.dy;
   assign dd[2] = in_side.dz;
   assign dd[3] = in_side.dw;
   assign root1 = (in_root == '0) ? ROOT_W'(1) : in_root;

   always_comb begin
      logic [D_W-1:0]        mag;
      logic [Q_W+FRAC_BITS-1:0] m;
      logic [FRAC_BITS-1:0]  hi;
      st_in.branch = in_side.branch;
      st_in.dv     = {root1, 1'b0};
      st_in.bigv   = val_type'({1'b0, in_root[ROOT_W-1:1]});
      for (int k = 0; k < 4; k++) begin
         st_in.lane[k].neg = dd[k][D_W-1];
         mag = dd[k][D_W-1] ? D_W'(-dd[k]) : D_W'(dd[k]);
         m   = {mag, {FRAC_BITS{1'b0}}};
         hi  = m[Q_W+FRAC_BITS-1:Q_W];
         st_in.lane[k].ovf = (DV_W'(hi) >= st_in.dv);
         st_in.lane[k].rem = st_in.lane[k].ovf ? '0 : DV_W'(hi);
         st_in.lane[k].num = m[Q_W-1:0];
         st_in.lane[k].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         st_ff[0] <= st_in;
      end
   end

   // One quotient bit per stage, four lanes side by side
   for (genvar g = 0; g < Q_W; g++) begin : g_bit
      dstage_type st_nx_in;

      always_comb begin
         logic [DV_W:0] rem_sh;
         logic          ge;
         st_nx_in = st_ff[g];
         for (int k = 0; k < 4; k++) begin
            rem_sh = {st_ff[g].lane[k].rem, st_ff[g].lane[k].num[Q_W-1]};
            ge     = (rem_sh >= {1'b0, st_ff[g].dv});
            st_nx_in.lane[k].rem = ge ? DV_W'(rem_sh - {1'b0, st_ff[g].dv})
                                      : DV_W'(rem_sh);
            st_nx_in.lane[k].num = st_ff[g].lane[k].num << 1;
            st_nx_in.lane[k].quo = {st_ff[g].lane[k].quo[Q_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g+1] <= 1'b0;
         end else if (en) begin
            valid_ff[g+1] <= valid_ff[g];
         end
         if (en) begin
            st_ff[g+1] <= st_nx_in;
         end
      end
   end

   // Sign, saturation and big-component select into the output register
   function automatic val_type sat_lane(lane_type ln);
      val_type r;
      if (!ln.neg) begin
         r = (ln.ovf || ln.quo > Q_W'(VAL_MAX)) ? VAL_MAX : val_type'(ln.quo);
      end else begin
         r = (ln.ovf || ln.quo > (Q_W'(1) << (VAL_W - 1))) ? VAL_MIN
                                                            : val_type'(-ln.quo);
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[Q_W];
      end
      if (en) begin
         branch_ff <= st_ff[Q_W].branch;
         q_ff[0] <= (st_ff[Q_W].branch == BR_X) ? st_ff[Q_W].bigv
                                                : sat_lane(st_ff[Q_W].lane[0]);
         q_ff[1] <= (st_ff[Q_W].branch == BR_Y) ? st_ff[Q_W].bigv
                                                : sat_lane(st_ff[Q_W].lane[1]);
         q_ff[2] <= (st_ff[Q_W].branch == BR_Z) ? st_ff[Q_W].bigv
                                                : sat_lane(st_ff[Q_W].lane[2]);
         q_ff[3] <= (st_ff[Q_W].branch == BR_TRACE) ? st_ff[Q_W].bigv
                                                    : sat_lane(st_ff[Q_W].lane[3]);
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_qx     = q_ff[0];
   assign out_qy     = q_ff[1];
   assign out_qz     = q_ff[2];
   assign out_qw     = q_ff[3];
   assign out_branch = branch_ff;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import rmq_pkg::*;

   localparam int NUM_RANDOM = 1430;
   localparam int TAIL_ITEMS = 200;
   localparam int LATENCY    = 4 + ROOT_W + Q_W;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      val_type r[9];
   } matrix_type;

   typedef struct {
      val_type    qx, qy, qz, qw;
      branch_type branch;
   } quat_type;

   // directed row: matrix plus an optional typed-in quaternion
   typedef struct {
      matrix_type m;
      bit         known;
      quat_type   q;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   val_type    req_r[9];
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   val_type    rsp_qx, rsp_qy, rsp_qz, rsp_qw;
   branch_type rsp_branch_taken;

   quat_type   pending_quats[$];
   int         mismatch_count = 0;
   int         cycle_count = 0;
   bit         stim_done = 1'b0;
   bit         quiet = 1'b0;

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < 9; i++) req_r[i] = '0;
   end

   rotation_matrix_to_quaternion_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_r11(req_r[0]), .req_r12(req_r[1]), .req_r13(req_r[2]),
      .req_r21(req_r[3]), .req_r22(req_r[4]), .req_r23(req_r[5]),
      .req_r31(req_r[6]), .req_r32(req_r[7]), .req_r33(req_r[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_qx(rsp_qx), .rsp_qy(rsp_qy), .rsp_qz(rsp_qz), .rsp_qw(rsp_qw),
      .rsp_branch_taken(rsp_branch_taken)
   );

   // bitwise integer square root, floor
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic val_type clamp_q(longint v);
      longint hi, lo;
      hi = (longint'(1) << (FRAC_BITS + 1)) - 1;
      lo = -(longint'(1) << (FRAC_BITS + 1));
      if (v > hi) return val_type'(hi);
      if (v < lo) return val_type'(lo);
      return val_type'(v);
   endfunction

   // Shepperd branch selection, root and quotients
   function automatic quat_type matrix_to_quat(matrix_type m);
      longint a[9];
      longint d[4];
      longint t, trace, one, divisor, q;
      longint unsigned root;
      int big;
      quat_type res;
      val_type comp[4];
      one = longint'(1) << FRAC_BITS;
      for (int i = 0; i < 9; i++) a[i] = longint'(m.r[i]);
      trace = a[0] + a[4] + a[8];
      if (trace > 0) begin
         res.branch = BR_TRACE; big = 3;
         t = trace + one;
         d[0] = a[7] - a[5]; d[1] = a[2] - a[6]; d[2] = a[3] - a[1]; d[3] = 0;
      end else if (a[0] > a[4] && a[0] > a[8]) begin
         res.branch = BR_X; big = 0;
         t = one + a[0] - a[4] - a[8];
         d[3] = a[7] - a[5]; d[1] = a[1] + a[3]; d[2] = a[2] + a[6]; d[0] = 0;
      end else if (a[4] > a[8]) begin
         res.branch = BR_Y; big = 1;
         t = one + a[4] - a[0] - a[8];
         d[3] = a[2] - a[6]; d[0] = a[1] + a[3]; d[2] = a[5] + a[7]; d[1] = 0;
      end else begin
         res.branch = BR_Z; big = 2;
         t = one + a[8] - a[0] - a[4];
         d[3] = a[3] - a[1]; d[0] = a[2] + a[6]; d[1] = a[5] + a[7]; d[2] = 0;
      end
      if (t < 0) t = 0;
      root = int_sqrt(longint'(t) * one);
      if (root == 0) root = 1;
      divisor = 2 * longint'(root);
      for (int k = 0; k < 4; k++) begin
         if (k == big) q = longint'(root >> 1);
         else q = (d[k] * one) / divisor;
         comp[k] = clamp_q(q);
      end
      res.qx = comp[0]; res.qy = comp[1]; res.qz = comp[2]; res.qw = comp[3];
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // random matrix: mostly near-rotation values, some raw noise and extremes
   function automatic matrix_type random_matrix();
      matrix_type m;
      int mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
         if (mode < 5)
            m.r[i] = val_type'($signed($urandom_range(0, 131072)) - 65536);
         else if (mode < 8)
            m.r[i] = val_type'($urandom);
         else
            case ($urandom_range(0, 3))
               0: m.r[i] = VAL_MAX;
               1: m.r[i] = VAL_MIN;
               2: m.r[i] = '0;
               default: m.r[i] = val_type'($urandom);
            endcase
      end
      // favor a dominant diagonal so every branch shows up often
      if (mode < 5 && $urandom_range(0, 1)) begin
         int j;
         j = $urandom_range(0, 2);
         m.r[j*4] = val_type'($urandom_range(50000, 131071));
      end
      return m;
   endfunction

   function automatic matrix_type diag(longint a, longint b, longint c);
      matrix_type m;
      for (int i = 0; i < 9; i++) m.r[i] = '0;
      m.r[0] = val_type'(a); m.r[4] = val_type'(b); m.r[8] = val_type'(c);
      return m;
   endfunction

   function automatic quat_type mk_q(longint x, longint y, longint z, longint w,
                                     branch_type b);
      quat_type q;
      q.qx = val_type'(x); q.qy = val_type'(y); q.qz = val_type'(z);
      q.qw = val_type'(w); q.branch = b;
      return q;
   endfunction

   // drive one item and hold until accepted
   task automatic send_matrix(matrix_type m, quat_type want);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      for (int i = 0; i < 9; i++) req_r[i] <= m.r[i];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_quats.push_back(want);
   endtask

   // receiver stalls in bursts
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_quats.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            quat_type w;
            w = pending_quats.pop_front();
            if (rsp_qx !== w.qx) report_mismatch("qx", rsp_qx, w.qx);
            if (rsp_qy !== w.qy) report_mismatch("qy", rsp_qy, w.qy);
            if (rsp_qz !== w.qz) report_mismatch("qz", rsp_qz, w.qz);
            if (rsp_qw !== w.qw) report_mismatch("qw", rsp_qw, w.qw);
            if (rsp_branch_taken !== w.branch)
               report_mismatch("branch", rsp_branch_taken, w.branch);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      row_type rows[$];
      row_type row;
      matrix_type m;
      quat_type q;
      longint one;
      one = longint'(1) << FRAC_BITS;

      // identity
      row.m = diag(one, one, one); row.known = 1;
      row.q = mk_q(0, 0, 0, 65536, BR_TRACE); rows.push_back(row);
      // 180 degrees about each axis
      row.m = diag(one, -one, -one); row.q = mk_q(65536, 0, 0, 0, BR_X);
      rows.push_back(row);
      row.m = diag(-one, one, -one); row.q = mk_q(0, 65536, 0, 0, BR_Y);
      rows.push_back(row);
      row.m = diag(-one, -one, one); row.q = mk_q(0, 0, 65536, 0, BR_Z);
      rows.push_back(row);
      // all zero: trace not positive, ties fall to the last branch
      row.m = diag(0, 0, 0); row.q = mk_q(0, 0, 32768, 0, BR_Z);
      rows.push_back(row);
      row.known = 0;
      // ties between diagonal elements
      rows.push_back('{m: diag(-one, -one, -one), known: 0, q: q});
      rows.push_back('{m: diag(0, 0, -one), known: 0, q: q});
      rows.push_back('{m: diag(-100, 0, -100), known: 0, q: q});
      // negative diagonals, with off-diagonal terms zero or at the extremes
      rows.push_back('{m: diag(VAL_MIN, VAL_MIN, VAL_MIN), known: 0, q: q});
      m = diag(-one, -one, -one);
      for (int i = 0; i < 9; i++) if (i % 4 != 0) m.r[i] = VAL_MAX;
      rows.push_back('{m: m, known: 0, q: q});
      for (int i = 0; i < 9; i++) if (i % 4 != 0) m.r[i] = VAL_MIN;
      rows.push_back('{m: m, known: 0, q: q});
      // field extremes
      m = diag(VAL_MAX, VAL_MAX, VAL_MAX);
      for (int i = 0; i < 9; i++) if (i % 4 != 0) m.r[i] = (i & 1) ? VAL_MAX : VAL_MIN;
      rows.push_back('{m: m, known: 0, q: q});
      m = diag(VAL_MIN, VAL_MAX, VAL_MIN);
      for (int i = 0; i < 9; i++) if (i % 4 != 0) m.r[i] = (i & 1) ? VAL_MIN : VAL_MAX;
      rows.push_back('{m: m, known: 0, q: q});
      m = diag(VAL_MIN, VAL_MIN, VAL_MAX);
      for (int i = 0; i < 9; i++) if (i % 4 != 0) m.r[i] = VAL_MAX;
      rows.push_back('{m: m, known: 0, q: q});
      // trace of exactly zero and one LSB
      rows.push_back('{m: diag(one, -one, 0), known: 0, q: q});
      rows.push_back('{m: diag(one, -one, 1), known: 0, q: q});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_matrix(rows[i].m, rows[i].known ? rows[i].q : matrix_to_quat(rows[i].m));
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == NUM_RANDOM - TAIL_ITEMS) quiet = 1'b1;
         m = random_matrix();
         send_matrix(m, matrix_to_quat(m));
      end
      req_valid <= 1'b0;

      while (pending_quats.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
